FILE: rtl/srr_pkg.sv
// Shared types, constants and saturation helpers for the room reverb.
package srr_pkg;

    localparam int SAMPLE_W = 16;
    localparam int INT_W    = 20;
    localparam int GAIN_W   = 16;

    // Q0.16 coefficients
    localparam logic [15:0] COEF_DAMP_NEW  = 16'd39322;  // 0.6
    localparam logic [15:0] COEF_DAMP_OLD  = 16'd26214;  // 0.4
    localparam logic [15:0] COEF_FEEDBACK  = 16'd48497;  // 0.74
    localparam logic [15:0] WET_GAIN_RESET = 16'd14418;

    // per-step enables for the comb datapath
    typedef struct packed {
        logic       mul_en;
        logic [1:0] mul_idx;
        logic       upd_en;
        logic [1:0] upd_idx;
        logic       fb_en;
    } comb_ctl_t;

    // per-step enables for the averaging, allpass and wet mix datapath
    typedef struct packed {
        logic sum_load;
        logic sum_add;
        logic ap_a_en;
        logic ap_b_en;
        logic wet_en;
    } tail_ctl_t;

    function automatic logic signed [INT_W-1:0] sat20(input logic signed [23:0] v);
        logic signed [INT_W-1:0] r;
        if (v > 24'sd524287) begin
            r = 20'sd524287;
        end else if (v < -24'sd524288) begin
            r = -20'sd524288;
        end else begin
            r = v[INT_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [23:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > 24'sd32767) begin
            r = 16'sd32767;
        end else if (v < -24'sd32768) begin
            r = -16'sd32768;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/srr_line_ram.sv
// Delay line memory: one write port, one read port, registered read data.
module srr_line_ram #(
    parameter int DEPTH  = 6269,
    parameter int ADDR_W = 13,
    parameter int DATA_W = 20
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/srr_comb_unit.sv
// Comb datapath: damping low-pass and feedback scaling, one comb per step.
module srr_comb_unit
    import srr_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  comb_ctl_t                  ctl,
    input  logic signed [INT_W-1:0]    line_y,
    input  logic signed [SAMPLE_W-1:0] dry,
    output logic signed [INT_W-1:0]    wr_data
);

    logic signed [INT_W-1:0] damp_reg [4];
    logic signed [36:0]      pa_reg;
    logic signed [36:0]      pb_reg;
    logic signed [INT_W-1:0] dn_reg;
    logic signed [36:0]      pf_reg;

    logic signed [37:0]      acc;
    logic signed [37:0]      acc_r;
    logic signed [21:0]      acc_q;
    logic signed [INT_W-1:0] dn;
    logic signed [36:0]      pf_r;
    logic signed [20:0]      pf_q;

    // damp = round(0.6*y + 0.4*damp)
    assign acc   = 38'(pa_reg) + 38'(pb_reg);
    assign acc_r = acc + 38'sd32768;
    assign acc_q = $signed(acc_r[37:16]);
    assign dn    = sat20(24'(acc_q));

    // line input = x + round(0.74*damp)
    assign pf_r    = pf_reg + 37'sd32768;
    assign pf_q    = $signed(pf_r[36:16]);
    assign wr_data = sat20(24'(dry) + 24'(pf_q));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                damp_reg[i] <= '0;
            end
        end else if (ctl.upd_en) begin
            damp_reg[ctl.upd_idx] <= dn;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            pa_reg <= 37'(line_y) * 37'($signed({1'b0, COEF_DAMP_NEW}));
            pb_reg <= 37'(damp_reg[ctl.mul_idx]) * 37'($signed({1'b0, COEF_DAMP_OLD}));
        end
        if (ctl.upd_en) begin
            dn_reg <= dn;
        end
        if (ctl.fb_en) begin
            pf_reg <= 37'(dn_reg) * 37'($signed({1'b0, COEF_FEEDBACK}));
        end
    end

endmodule

FILE: rtl/srr_tail_unit.sv
// Comb averaging, two allpass stages sharing one datapath, and wet/dry mix.
module srr_tail_unit
    import srr_pkg::*;
(
    input  logic                       aclk,
    input  tail_ctl_t                  ctl,
    input  logic signed [INT_W-1:0]    line_b,
    input  logic signed [SAMPLE_W-1:0] dry,
    input  logic [GAIN_W-1:0]          wet_gain,
    output logic signed [INT_W-1:0]    wa,
    output logic signed [INT_W-1:0]    wb,
    output logic signed [SAMPLE_W-1:0] mix
);

    logic signed [21:0]      sum_reg;
    logic signed [INT_W-1:0] ap_out_reg;
    logic signed [INT_W-1:0] wa_reg;
    logic signed [INT_W-1:0] wb_reg;
    logic signed [36:0]      p_reg;

    logic signed [21:0]      sum_r;
    logic signed [INT_W-1:0] avg;
    logic signed [INT_W-1:0] ap_x;
    logic signed [20:0]      b_r;
    logic signed [INT_W-1:0] b_half;
    logic signed [INT_W-1:0] ap_y;
    logic signed [INT_W-1:0] ap_w;
    logic signed [36:0]      p_r;
    logic signed [20:0]      p_q;

    // sum of four 20-bit values times 0.25 always fits 20 bits
    assign sum_r = sum_reg + 22'sd2;
    assign avg   = $signed(sum_r[21:2]);

    assign ap_x   = ctl.ap_a_en ? avg : ap_out_reg;
    assign b_r    = 21'(line_b) + 21'sd1;
    assign b_half = $signed(b_r[20:1]);
    assign ap_y   = sat20(24'(line_b) - 24'(ap_x));
    assign ap_w   = sat20(24'(ap_x) + 24'(b_half));

    assign p_r = p_reg + 37'sd32768;
    assign p_q = $signed(p_r[36:16]);
    assign mix = sat16(24'(dry) + 24'(p_q));

    assign wa = wa_reg;
    assign wb = wb_reg;

    always_ff @(posedge aclk) begin
        if (ctl.sum_load) begin
            sum_reg <= 22'(line_b);
        end else if (ctl.sum_add) begin
            sum_reg <= sum_reg + 22'(line_b);
        end
        if (ctl.ap_a_en || ctl.ap_b_en) begin
            ap_out_reg <= ap_y;
        end
        if (ctl.ap_a_en) begin
            wa_reg <= ap_w;
        end
        if (ctl.ap_b_en) begin
            wb_reg <= ap_w;
        end
        if (ctl.wet_en) begin
            p_reg <= 37'(ap_out_reg) * 37'($signed({1'b0, wet_gain}));
        end
    end

endmodule

FILE: rtl/schroeder_room_reverb_top.sv
// Top level of the room reverb: sequencer, line addressing, ports and checks.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  s_      | in  | s_tvalid / s_tready  | s_tdata[15:0] sample_in, s_tlast sound_end
//  m_      | out | m_tvalid / m_tready  | m_tdata[15:0] sample_out, m_tlast sound_end_out
//  cfg_    | in  | cfg_valid / cfg_ready| cfg_data[15:0] wet_gain
//
// Each item runs the steps STEP_RD_A to STEP_LAST, a span set by the single write
// port of the shared line memory: six line reads and six write-backs (four combs,
// two allpasses). The next item is taken in the last cycle of the current one.
// After reset the line memory is cleared, one entry per cycle, through all
// COMB_LEN_A+..+ALLPASS_LEN_B entries (6269 at the defaults); no item is
// accepted meanwhile, config writes are taken at any time.
// A result waits in the output register; a stalled m_ side holds the
// sequencer only when the next result is ready to be loaded.
module schroeder_room_reverb_top
    import srr_pkg::*;
#(
    parameter int COMB_LEN_A    = 1116,
    parameter int COMB_LEN_B    = 1277,
    parameter int COMB_LEN_C    = 1422,
    parameter int COMB_LEN_D    = 1557,
    parameter int ALLPASS_LEN_A = 556,
    parameter int ALLPASS_LEN_B = 341
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample_in (signed)
    input  logic        s_tlast,   // sound_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] sample_out (signed)
    output logic        m_tlast,   // sound_end_out
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // [15:0] wet_gain
);

    // all six lines live back to back in one memory
    localparam int BASE_A  = 0;
    localparam int BASE_B  = BASE_A + COMB_LEN_A;
    localparam int BASE_C  = BASE_B + COMB_LEN_B;
    localparam int BASE_D  = BASE_C + COMB_LEN_C;
    localparam int BASE_PA = BASE_D + COMB_LEN_D;
    localparam int BASE_PB = BASE_PA + ALLPASS_LEN_A;
    localparam int DEPTH   = BASE_PB + ALLPASS_LEN_B;
    localparam int ADDR_W  = $clog2(DEPTH);

    localparam int CA_W = $clog2(COMB_LEN_A);
    localparam int CB_W = $clog2(COMB_LEN_B);
    localparam int CC_W = $clog2(COMB_LEN_C);
    localparam int CD_W = $clog2(COMB_LEN_D);
    localparam int PA_W = $clog2(ALLPASS_LEN_A);
    localparam int PB_W = $clog2(ALLPASS_LEN_B);

    // sequencer steps
    localparam logic [3:0] STEP_RD_A  = 4'd0;  // read comb A
    localparam logic [3:0] STEP_Y_A   = 4'd1;  // comb A data back
    localparam logic [3:0] STEP_Y_B   = 4'd2;
    localparam logic [3:0] STEP_Y_C   = 4'd3;
    localparam logic [3:0] STEP_Y_D   = 4'd4;  // also first comb write
    localparam logic [3:0] STEP_AP_A  = 4'd5;  // allpass A data back
    localparam logic [3:0] STEP_AP_B  = 4'd6;
    localparam logic [3:0] STEP_WET   = 4'd7;  // last comb write
    localparam logic [3:0] STEP_MIX   = 4'd8;  // load output, write allpass A
    localparam logic [3:0] STEP_LAST  = 4'd9;  // write allpass B, advance lines

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [3:0]       step_reg;
    logic [3:0]       step_next;
    logic [ADDR_W-1:0] clr_addr_reg;

    logic [CA_W-1:0] pos_a_reg;
    logic [CB_W-1:0] pos_b_reg;
    logic [CC_W-1:0] pos_c_reg;
    logic [CD_W-1:0] pos_d_reg;
    logic [PA_W-1:0] pos_pa_reg;
    logic [PB_W-1:0] pos_pb_reg;

    logic [GAIN_W-1:0]          wet_gain_reg;
    logic signed [SAMPLE_W-1:0] dry_reg;
    logic                       last_reg;
    logic                       m_tvalid_reg;
    logic [15:0]                m_tdata_reg;
    logic                       m_tlast_reg;

    logic              in_acc;
    logic              run;
    logic              out_free;
    logic              adv;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [INT_W-1:0]  wr_data;
    logic [INT_W-1:0]  rd_data;
    logic [1:0]        wr_idx;

    comb_ctl_t                  comb_ctl;
    tail_ctl_t                  tail_ctl;
    logic signed [INT_W-1:0]    comb_wr;
    logic signed [INT_W-1:0]    ap_wa;
    logic signed [INT_W-1:0]    ap_wb;
    logic signed [SAMPLE_W-1:0] mix;

    assign run      = (state_reg == ST_RUN);
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) || (run && step_reg == STEP_LAST);
    assign in_acc   = s_tvalid && s_tready;
    assign adv      = run && !(step_reg == STEP_MIX && !out_free);
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    state_next = ST_RUN;
                    step_next  = STEP_RD_A;
                end
            end
            ST_RUN: begin
                if (step_reg == STEP_LAST) begin
                    // back-to-back item starts straight away
                    state_next = in_acc ? ST_RUN : ST_IDLE;
                    step_next  = STEP_RD_A;
                end else if (adv) begin
                    step_next = step_reg + 4'd1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            step_reg     <= STEP_RD_A;
            clr_addr_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (run && step_reg == STEP_MIX && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (run && step_reg == STEP_MIX && out_free) begin
            m_tdata_reg <= mix;
            m_tlast_reg <= last_reg;
        end
        if (in_acc) begin
            dry_reg  <= $signed(s_tdata);
            last_reg <= s_tlast;
        end
    end

    // line read/write positions, advanced once per item, and the wet gain register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_a_reg    <= '0;
            pos_b_reg    <= '0;
            pos_c_reg    <= '0;
            pos_d_reg    <= '0;
            pos_pa_reg   <= '0;
            pos_pb_reg   <= '0;
            wet_gain_reg <= WET_GAIN_RESET;
        end else begin
            if (run && step_reg == STEP_LAST) begin
                pos_a_reg  <= (pos_a_reg == CA_W'(COMB_LEN_A - 1)) ? '0 : pos_a_reg + CA_W'(1);
                pos_b_reg  <= (pos_b_reg == CB_W'(COMB_LEN_B - 1)) ? '0 : pos_b_reg + CB_W'(1);
                pos_c_reg  <= (pos_c_reg == CC_W'(COMB_LEN_C - 1)) ? '0 : pos_c_reg + CC_W'(1);
                pos_d_reg  <= (pos_d_reg == CD_W'(COMB_LEN_D - 1)) ? '0 : pos_d_reg + CD_W'(1);
                pos_pa_reg <= (pos_pa_reg == PA_W'(ALLPASS_LEN_A - 1)) ?
                              '0 : pos_pa_reg + PA_W'(1);
                pos_pb_reg <= (pos_pb_reg == PB_W'(ALLPASS_LEN_B - 1)) ?
                              '0 : pos_pb_reg + PB_W'(1);
            end
            if (cfg_valid && cfg_ready) begin
                wet_gain_reg <= cfg_data;
            end
        end
    end

    // ---------------------------------------------------------------
    // memory addressing
    // ---------------------------------------------------------------
    always_comb begin
        rd_en   = run;
        rd_addr = '0;
        unique case (step_reg)
            STEP_RD_A: rd_addr = ADDR_W'(BASE_A) + ADDR_W'(pos_a_reg);
            STEP_Y_A:  rd_addr = ADDR_W'(BASE_B) + ADDR_W'(pos_b_reg);
            STEP_Y_B:  rd_addr = ADDR_W'(BASE_C) + ADDR_W'(pos_c_reg);
            STEP_Y_C:  rd_addr = ADDR_W'(BASE_D) + ADDR_W'(pos_d_reg);
            STEP_Y_D:  rd_addr = ADDR_W'(BASE_PA) + ADDR_W'(pos_pa_reg);
            STEP_AP_A: rd_addr = ADDR_W'(BASE_PB) + ADDR_W'(pos_pb_reg);
            default:   rd_en   = 1'b0;
        endcase
    end

    assign wr_idx = 2'(step_reg - STEP_Y_D);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        if (state_reg == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
        end else if (run) begin
            unique case (step_reg)
                STEP_Y_D, STEP_AP_A, STEP_AP_B, STEP_WET: begin
                    wr_en   = 1'b1;
                    wr_data = comb_wr;
                    unique case (wr_idx)
                        2'd0:    wr_addr = ADDR_W'(BASE_A) + ADDR_W'(pos_a_reg);
                        2'd1:    wr_addr = ADDR_W'(BASE_B) + ADDR_W'(pos_b_reg);
                        2'd2:    wr_addr = ADDR_W'(BASE_C) + ADDR_W'(pos_c_reg);
                        default: wr_addr = ADDR_W'(BASE_D) + ADDR_W'(pos_d_reg);
                    endcase
                end
                // rewrite during an output stall is harmless: same entry, same data
                STEP_MIX: begin
                    wr_en   = 1'b1;
                    wr_addr = ADDR_W'(BASE_PA) + ADDR_W'(pos_pa_reg);
                    wr_data = ap_wa;
                end
                STEP_LAST: begin
                    wr_en   = 1'b1;
                    wr_addr = ADDR_W'(BASE_PB) + ADDR_W'(pos_pb_reg);
                    wr_data = ap_wb;
                end
                default: wr_en = 1'b0;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // datapath control: comb pipeline is mul -> update -> feedback -> write
    // ---------------------------------------------------------------
    always_comb begin
        comb_ctl.mul_en  = run && step_reg >= STEP_Y_A && step_reg <= STEP_Y_D;
        comb_ctl.mul_idx = 2'(step_reg - STEP_Y_A);
        comb_ctl.upd_en  = run && step_reg >= STEP_Y_B && step_reg <= STEP_AP_A;
        comb_ctl.upd_idx = 2'(step_reg - STEP_Y_B);
        comb_ctl.fb_en   = run && step_reg >= STEP_Y_C && step_reg <= STEP_AP_B;

        tail_ctl.sum_load = run && step_reg == STEP_Y_A;
        tail_ctl.sum_add  = run && step_reg >= STEP_Y_B && step_reg <= STEP_Y_D;
        tail_ctl.ap_a_en  = run && step_reg == STEP_AP_A;
        tail_ctl.ap_b_en  = run && step_reg == STEP_AP_B;
        tail_ctl.wet_en   = run && step_reg == STEP_WET;
    end

    srr_line_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (INT_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    srr_comb_unit u_comb (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (comb_ctl),
        .line_y  ($signed(rd_data)),
        .dry     (dry_reg),
        .wr_data (comb_wr)
    );

    srr_tail_unit u_tail (
        .aclk     (aclk),
        .ctl      (tail_ctl),
        .line_b   ($signed(rd_data)),
        .dry      (dry_reg),
        .wet_gain (wet_gain_reg),
        .wa       (ap_wa),
        .wb       (ap_wb),
        .mix      (mix)
    );

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    // a read never targets the entry being written in the same cycle
    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("line memory read/write collision");

    // a new result only appears from the mix step
    a_out_from_mix: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(run && step_reg == STEP_MIX))
        else $error("output loaded outside mix step");

    // positions stay inside their lines
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        run |-> (pos_a_reg <= CA_W'(COMB_LEN_A - 1)) && (pos_b_reg <= CB_W'(COMB_LEN_B - 1))
             && (pos_c_reg <= CC_W'(COMB_LEN_C - 1)) && (pos_d_reg <= CD_W'(COMB_LEN_D - 1))
             && (pos_pa_reg <= PA_W'(ALLPASS_LEN_A - 1))
             && (pos_pb_reg <= PB_W'(ALLPASS_LEN_B - 1)))
        else $error("line position out of range");

endmodule

FILE: tb/schroeder_room_reverb_top_test.sv
// Self-checking testbench for the room reverb: stream driver, result monitor, sample predictor.
module schroeder_room_reverb_top_test
    import srr_pkg::*;
;

    localparam int COMB_LEN_A    = 1116;
    localparam int COMB_LEN_B    = 1277;
    localparam int COMB_LEN_C    = 1422;
    localparam int COMB_LEN_D    = 1557;
    localparam int ALLPASS_LEN_A = 556;
    localparam int ALLPASS_LEN_B = 341;

    // The line clear after reset runs with no item taken, so the quiet-cycle
    // limit sits well above the length of the clear.
    localparam int STALL_LIMIT = 30000;
    localparam int TAIL_CYCLES = 40;

    localparam longint DAMP_NEW = longint'(COEF_DAMP_NEW);
    localparam longint DAMP_OLD = longint'(COEF_DAMP_OLD);
    localparam longint FEEDBACK = longint'(COEF_FEEDBACK);

    typedef struct packed {
        logic               last;
        logic signed [15:0] sample;
    } audio_t;

    typedef enum int {
        SOUND_NOISE,
        SOUND_HOLD,
        SOUND_SQUARE,
        SOUND_QUIET
    } sound_style_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;   // [15:0] sample_in (signed)
    logic        s_tlast   = 1'b0; // sound_end
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;          // [15:0] sample_out (signed)
    logic        m_tlast;          // sound_end_out
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;   // [15:0] wet_gain

    // predictor state: comb lines, damping, allpass lines, indices, gain
    logic signed [19:0] comb_mem [4][2048];
    logic signed [19:0] ap_mem [2][1024];
    logic signed [19:0] damp_q [4];
    int                 comb_ptr [4];
    int                 ap_ptr [2];
    logic [15:0]        wet_gain_now = WET_GAIN_RESET;

    audio_t pending_samples[$];
    audio_t expected_mix[$];
    audio_t shown_item;
    audio_t want;

    int send_gap_pct   = 23;
    int recv_stall_pct = 68;
    int err_count      = 0;
    int quiet_cycles   = 0;

    schroeder_room_reverb_top #(
        .COMB_LEN_A   (COMB_LEN_A),
        .COMB_LEN_B   (COMB_LEN_B),
        .COMB_LEN_C   (COMB_LEN_C),
        .COMB_LEN_D   (COMB_LEN_D),
        .ALLPASS_LEN_A(ALLPASS_LEN_A),
        .ALLPASS_LEN_B(ALLPASS_LEN_B)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #5 aclk = ~aclk;

    // floor((v + 2^(s-1)) / 2^s)
    function automatic longint round_shr(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [19:0] clip20(longint v);
        if (v > 524287) begin
            return 20'sd524287;
        end
        if (v < -524288) begin
            return -20'sd524288;
        end
        return v[19:0];
    endfunction

    // One sample through four damped combs, the average, two allpasses, wet mix.
    function automatic audio_t predict_reverb(audio_t din);
        longint             acc;
        longint             sum;
        logic signed [19:0] y;
        logic signed [19:0] b;
        logic signed [19:0] v;
        int                 len;
        int                 k;
        audio_t             r;
        sum = 0;
        for (int c = 0; c < 4; c++) begin
            case (c)
                0: len = COMB_LEN_A;
                1: len = COMB_LEN_B;
                2: len = COMB_LEN_C;
                default: len = COMB_LEN_D;
            endcase
            k = comb_ptr[c];
            y = comb_mem[c][k];
            acc = longint'(y) * DAMP_NEW + longint'(damp_q[c]) * DAMP_OLD;
            damp_q[c] = clip20(round_shr(acc, 16));
            comb_mem[c][k] = clip20(longint'(din.sample)
                                    + round_shr(longint'(damp_q[c]) * FEEDBACK, 16));
            comb_ptr[c] = (k + 1 >= len) ? 0 : k + 1;
            sum += longint'(y);
        end
        v = clip20(round_shr(sum, 2));
        for (int a = 0; a < 2; a++) begin
            len = (a == 0) ? ALLPASS_LEN_A : ALLPASS_LEN_B;
            k = ap_ptr[a];
            b = ap_mem[a][k];
            ap_mem[a][k] = clip20(longint'(v) + round_shr(longint'(b), 1));
            ap_ptr[a] = (k + 1 >= len) ? 0 : k + 1;
            v = clip20(longint'(b) - longint'(v));
        end
        sum = longint'(din.sample) + round_shr(longint'(v) * longint'(wet_gain_now), 16);
        if (sum > 32767) begin
            sum = 32767;
        end else if (sum < -32768) begin
            sum = -32768;
        end
        r.sample = sum[15:0];
        r.last   = din.last;
        return r;
    endfunction

    // Driver: holds an item until taken, predicts on every handshake.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_mix.push_back(predict_reverb(shown_item));
            end
            if (!s_tvalid || s_tready) begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    shown_item = pending_samples.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= shown_item.sample;
                    s_tlast  <= shown_item.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random backpressure, in-order compare against predictions.
    always @(posedge aclk) begin
        m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_mix.size() == 0) begin
                $error("unexpected item: sample_out %0d", $signed(m_tdata));
                err_count++;
            end else begin
                want = expected_mix.pop_front();
                if (m_tdata !== want.sample) begin
                    $error("sample_out: expected %0d, got %0d", want.sample, $signed(m_tdata));
                    err_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("sound_end_out: expected %0b, got %0b", want.last, m_tlast);
                    err_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on any channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles > STALL_LIMIT) begin
            $display("schroeder_room_reverb_top_test: done, errors");
            $finish;
        end
    end

    task automatic wait_drained();
        @(negedge aclk);
        while (pending_samples.size() != 0 || s_tvalid || expected_mix.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // only called with nothing in flight
    task automatic write_wet_gain(input logic [15:0] gain);
        @(posedge aclk);
        cfg_data  <= gain;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        wet_gain_now = gain;
    endtask

    // Queues sounds: runs of one style, mostly closed by sound_end, with
    // stray end flags mid-run.
    task automatic fill_sounds(input int count);
        sound_style_t style;
        int           len;
        int           period;
        int           amp;
        logic [15:0]  level;
        audio_t       it;
        @(negedge aclk);
        while (count > 0) begin
            style  = sound_style_t'($urandom_range(3));
            len    = (style == SOUND_HOLD) ? $urandom_range(150, 500) : $urandom_range(4, 120);
            period = $urandom_range(2, 64);
            amp    = $urandom_range(16384, 32767);
            level  = $urandom_range(1) ? 16'h7fff : 16'h8000;
            if (len > count) begin
                len = count;
            end
            for (int i = 0; i < len; i++) begin
                case (style)
                    SOUND_NOISE:  it.sample = $urandom_range(16'hffff);
                    // full scale, low bits jittered now and then
                    SOUND_HOLD:   it.sample = ($urandom_range(7) == 0)
                                              ? (level ^ 16'($urandom_range(255))) : level;
                    SOUND_SQUARE: it.sample = ((i / period) % 2) ? 16'(-amp) : 16'(amp);
                    default:      it.sample = 16'($signed($urandom_range(127)) - 64);
                endcase
                if (i == len - 1) begin
                    it.last = ($urandom_range(9) != 0);
                end else begin
                    it.last = ($urandom_range(31) == 0);
                end
                pending_samples.push_back(it);
            end
            count -= len;
        end
    endtask

    initial begin
        logic [16:0] directed [20] = '{
            {1'b0, 16'h0000}, {1'b0, 16'h7fff}, {1'b0, 16'h8000}, {1'b0, 16'h0001},
            {1'b0, 16'hffff}, {1'b1, 16'h7fff}, {1'b0, 16'h8000}, {1'b0, 16'h5555},
            {1'b0, 16'haaaa}, {1'b1, 16'h0000}, {1'b0, 16'h7fff}, {1'b0, 16'h7fff},
            {1'b0, 16'h7fff}, {1'b1, 16'h7fff}, {1'b0, 16'h8000}, {1'b0, 16'h8000},
            {1'b0, 16'h8000}, {1'b1, 16'h8000}, {1'b0, 16'h00ff}, {1'b1, 16'hff00}
        };
        audio_t it;
        for (int c = 0; c < 4; c++) begin
            damp_q[c]   = '0;
            comb_ptr[c] = 0;
            for (int i = 0; i < 2048; i++) begin
                comb_mem[c][i] = '0;
            end
        end
        for (int a = 0; a < 2; a++) begin
            ap_ptr[a] = 0;
            for (int i = 0; i < 1024; i++) begin
                ap_mem[a][i] = '0;
            end
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Phase 1: reset gain, sender gaps light, receiver stalls heavy.
        // Extremes and end flags back to back; the lines keep running across
        // sound ends, so later phases see the tail of earlier ones.
        @(negedge aclk);
        foreach (directed[i]) begin
            it = directed[i];
            pending_samples.push_back(it);
        end
        fill_sounds(400);
        wait_drained();

        // Phase 2: full-scale wet gain, roles of the two sides swapped.
        // Halfway through the sender holds off until all results are back.
        send_gap_pct   = 68;
        recv_stall_pct = 23;
        write_wet_gain(16'hffff);
        fill_sounds(200);
        wait_drained();
        fill_sounds(200);
        wait_drained();

        // Phase 3: dry only, no idling on either side.
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        write_wet_gain(16'h0000);
        fill_sounds(100);
        wait_drained();

        // Phase 4: random gain, still at full rate.
        write_wet_gain(16'($urandom_range(16'hffff)));
        fill_sounds(430);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("schroeder_room_reverb_top_test: done, clean");
        end else begin
            $display("schroeder_room_reverb_top_test: done, errors");
        end
        $finish;
    end

endmodule
